@@ hdl/landmark_association_table_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Landmark association table: assertion macros
// Concurrent assertion shorthands clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LANDMARK_ASSOCIATION_TABLE_UNIT_MACROS_SVH
`define LANDMARK_ASSOCIATION_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define LAT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LAT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lat_pkg.sv @@
// ----------------------------------------------------------------------------
// Landmark association table package
// Sizes, entry layout, state encoding and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lat_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

   // divider: magnitude of dividend and divisor
   localparam int DIV_W  = 40;
   localparam int DEN_W  = 17;
   // square root: sum of four squared Q1.14 values, top bit index even
   localparam int SQ_W   = 33;
   localparam int ROOT_W = 17;

   localparam logic signed [15:0] Q_ONE   = 16'sd16384;
   localparam logic signed [31:0] Z_ONE   = 32'sd65536;
   localparam logic signed [31:0] Z_TWO   = 32'sd131072;
   localparam logic signed [31:0] Z_SPLIT = 32'sd98304;

   localparam logic [30:0] RADIUS_RST = 31'd65536;
   localparam logic [6:0]  LIMIT_RST  = 7'd100;
   localparam logic        SNAP_RST   = 1'b1;

   localparam logic CMD_OBSERVE = 1'b0;
   localparam logic CMD_CLEAR   = 1'b1;

   localparam logic [1:0] CSR_MATCH_RADIUS = 2'd0;
   localparam logic [1:0] CSR_COUNT_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_SNAP_HEIGHT  = 2'd2;

   typedef struct packed {
      logic [15:0]      key;
      logic [7:0]       count;
      logic [15:0]      ident;
      logic [2:0][31:0] pos;
      logic [3:0][15:0] quat;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SQ,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_NORM_GO,
      ST_NORM_WAIT,
      ST_STORE,
      ST_RESULT
   } state_type;

endpackage

@@ hdl/landmark_association_table_unit.sv @@
// Clear goes straight to the result. Observe reads and compares stored entries in
// turn; a match within the count limit is averaged in 7 multiply-and-divide steps
// through the shared divider, a square root and 4 normalizing divisions.
// One item in flight; the next is taken when the result is registered.
// Reset empties the table through the fill count, no clearing pass.
// ----------------------------------------------------------------------------
// Landmark association table unit
// Associates tagged landmark observations with stored entries and keeps a
// running mean of position and normalized orientation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module landmark_association_table_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [15:0]        req_tag_key,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_entry_id,
   output logic               rsp_is_new,
   output logic               rsp_table_full,
   output logic [7:0]         rsp_sample_count,
   output logic signed [31:0] rsp_mean_x,
   output logic signed [31:0] rsp_mean_y,
   output logic signed [31:0] rsp_mean_z,
   output logic signed [15:0] rsp_mean_qx,
   output logic signed [15:0] rsp_mean_qy,
   output logic signed [15:0] rsp_mean_qz,
   output logic signed [15:0] rsp_mean_qw,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wr_data
);
   import lat_pkg::*;

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic [15:0]       next_id_ff, next_id_in;
   logic [30:0]       radius_ff;
   logic [6:0]        limit_ff;
   logic              snap_ff;

   logic [15:0]       key_ff, key_in;
   logic [2:0][31:0]  obs_pos_ff, obs_pos_in;
   logic [3:0][15:0]  obs_quat_ff, obs_quat_in;
   entry_type         ent_ff, ent_in;
   logic              new_ff, new_in;
   logic              full_ff, full_in;
   logic              zero_ff, zero_in;
   logic [2:0]        comp_ff, comp_in;
   logic signed [40:0] prod_ff, prod_in;
   logic              sign_ff, sign_in;
   logic [SQ_W-1:0]   sum_ff, sum_in;
   logic [ROOT_W-1:0] norm_ff, norm_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_id_ff, rsp_id_in;
   logic              rsp_new_ff, rsp_new_in;
   logic              rsp_full_ff, rsp_full_in;
   logic [7:0]        rsp_count_ff, rsp_count_in;
   logic [2:0][31:0]  rsp_pos_ff, rsp_pos_in;
   logic [3:0][15:0]  rsp_quat_ff, rsp_quat_in;

   logic              accept;
   logic              rsp_free;
   logic              rd_en;
   logic              wr_en;
   logic [ENTRY_W-1:0] rd_data;
   entry_type         rd_ent;
   logic              div_start;
   logic [DIV_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic              div_done;
   logic [DIV_W-1:0]  div_quo;
   logic              sqrt_start;
   logic              sqrt_done;
   logic [ROOT_W-1:0] sqrt_root;

   logic [2:0]         qoff;
   logic [1:0]         qidx;
   logic signed [31:0] old_sel;
   logic signed [31:0] new_sel;
   logic signed [40:0] num_full;
   logic signed [40:0] num_abs;
   logic [8:0]         cnt_den;
   logic [DIV_W-1:0]   quo_signed;
   logic [15:0]        qmag;
   logic signed [31:0] qsx;
   logic [31:0]        csq;
   logic               match;

   function automatic logic within_radius(input logic [31:0] a, input logic [31:0] b,
                                          input logic [30:0] r);
      logic signed [32:0] d;
      logic [32:0]        ad;
      d  = $signed({a[31], a}) - $signed({b[31], b});
      ad = d[32] ? 33'(-d) : 33'(d);
      return ad <= {2'b00, r};
   endfunction

   lat_entry_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff[IDX_W-1:0]),
      .wr_data (ent_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   lat_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   lat_isqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .val   (sum_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_ent    = entry_type'(rd_data);

   always_comb begin
      qoff     = comp_ff - 3'd3;
      qidx     = qoff[1:0];
      old_sel  = (comp_ff < 3'd3) ? $signed(ent_ff.pos[comp_ff[1:0]])
                 : $signed({{16{ent_ff.quat[qidx][15]}}, ent_ff.quat[qidx]});
      new_sel  = (comp_ff < 3'd3) ? $signed(obs_pos_ff[comp_ff[1:0]])
                 : $signed({{16{obs_quat_ff[qidx][15]}}, obs_quat_ff[qidx]});
      cnt_den  = {1'b0, ent_ff.count} + 9'd1;
      if (state_ff == ST_NORM_GO) begin
         num_full = $signed({{25{ent_ff.quat[comp_ff[1:0]][15]}},
                             ent_ff.quat[comp_ff[1:0]]}) <<< 14;
      end else begin
         num_full = prod_ff + $signed({{9{new_sel[31]}}, new_sel});
      end
      num_abs    = num_full[40] ? -num_full : num_full;
      quo_signed = sign_ff ? -div_quo : div_quo;
      qmag       = (div_quo > DIV_W'(Q_ONE)) ? Q_ONE : div_quo[15:0];
      qsx        = $signed({{16{ent_ff.quat[comp_ff[1:0]][15]}},
                            ent_ff.quat[comp_ff[1:0]]});
      csq        = $unsigned(qsx * qsx);
      match      = (rd_ent.key == key_ff)
                   && within_radius(rd_ent.pos[0], obs_pos_ff[0], radius_ff)
                   && within_radius(rd_ent.pos[1], obs_pos_ff[1], radius_ff)
                   && within_radius(rd_ent.pos[2], obs_pos_ff[2], radius_ff);
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      next_id_in   = next_id_ff;
      key_in       = key_ff;
      obs_pos_in   = obs_pos_ff;
      obs_quat_in  = obs_quat_ff;
      ent_in       = ent_ff;
      new_in       = new_ff;
      full_in      = full_ff;
      zero_in      = zero_ff;
      comp_in      = comp_ff;
      prod_in      = prod_ff;
      sign_in      = sign_ff;
      sum_in       = sum_ff;
      norm_in      = norm_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_count_in = rsp_count_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_quat_in  = rsp_quat_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      sqrt_start   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               new_in  = 1'b0;
               full_in = 1'b0;
               if (req_cmd == CMD_CLEAR) begin
                  fill_in  = '0;
                  zero_in  = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  zero_in        = 1'b0;
                  key_in         = req_tag_key;
                  obs_pos_in[0]  = req_pos_x;
                  obs_pos_in[1]  = req_pos_y;
                  obs_pos_in[2]  = req_pos_z;
                  obs_quat_in[0] = req_quat_x;
                  obs_quat_in[1] = req_quat_y;
                  obs_quat_in[2] = req_quat_z;
                  obs_quat_in[3] = req_quat_w;
                  idx_in         = '0;
                  state_in       = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (idx_ff == fill_ff) begin
               if (fill_ff == FILL_W'(TABLE_DEPTH)) begin
                  full_in  = 1'b1;
                  zero_in  = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  ent_in.key   = key_ff;
                  ent_in.count = 8'd1;
                  ent_in.ident = next_id_ff;
                  ent_in.pos   = obs_pos_ff;
                  ent_in.quat  = obs_quat_ff;
                  new_in       = 1'b1;
                  fill_in      = fill_ff + 1'b1;
                  next_id_in   = next_id_ff + 16'd1;
                  state_in     = ST_STORE;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (match) begin
               ent_in = rd_ent;
               if (rd_ent.count <= {1'b0, limit_ff}) begin
                  comp_in  = '0;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_RESULT;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_MUL: begin
            prod_in  = old_sel * $signed({1'b0, ent_ff.count});
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            sign_in   = num_full[40];
            div_den   = DEN_W'(cnt_den);
            div_num   = num_abs[DIV_W-1:0] + DIV_W'(cnt_den >> 1);
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (comp_ff < 3'd3) begin
                  ent_in.pos[comp_ff[1:0]] = quo_signed[31:0];
               end else begin
                  ent_in.quat[qidx] = quo_signed[15:0];
               end
               if (comp_ff == 3'd6) begin
                  comp_in  = '0;
                  sum_in   = '0;
                  state_in = ST_SQ;
               end else begin
                  comp_in  = comp_ff + 3'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_SQ: begin
            sum_in  = sum_ff + {1'b0, csq};
            comp_in = comp_ff + 3'd1;
            if (comp_ff == 3'd3) begin
               state_in = ST_SQRT_GO;
            end
         end
         ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               norm_in = sqrt_root;
               if (sqrt_root == '0) begin
                  ent_in.quat  = {Q_ONE, 16'd0, 16'd0, 16'd0};
                  ent_in.count = ent_ff.count + 8'd1;
                  state_in     = ST_STORE;
               end else begin
                  comp_in  = '0;
                  state_in = ST_NORM_GO;
               end
            end
         end
         ST_NORM_GO: begin
            sign_in   = num_full[40];
            div_den   = norm_ff;
            div_num   = num_abs[DIV_W-1:0] + DIV_W'(norm_ff >> 1);
            div_start = 1'b1;
            state_in  = ST_NORM_WAIT;
         end
         ST_NORM_WAIT: begin
            if (div_done) begin
               ent_in.quat[comp_ff[1:0]] = sign_ff ? -qmag : qmag;
               if (comp_ff == 3'd3) begin
                  ent_in.count = ent_ff.count + 8'd1;
                  state_in     = ST_STORE;
               end else begin
                  comp_in  = comp_ff + 3'd1;
                  state_in = ST_NORM_GO;
               end
            end
         end
         ST_STORE: begin
            wr_en    = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_full_in  = full_ff;
               if (zero_ff) begin
                  rsp_id_in    = '0;
                  rsp_new_in   = 1'b0;
                  rsp_count_in = '0;
                  rsp_pos_in   = '0;
                  rsp_quat_in  = '0;
               end else begin
                  rsp_id_in     = ent_ff.ident;
                  rsp_new_in    = new_ff;
                  rsp_count_in  = ent_ff.count;
                  rsp_pos_in    = ent_ff.pos;
                  rsp_quat_in   = ent_ff.quat;
                  if (snap_ff) begin
                     rsp_pos_in[2] = ($signed(ent_ff.pos[2]) < Z_SPLIT) ? Z_ONE : Z_TWO;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         next_id_ff   <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         next_id_ff   <= next_id_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         limit_ff  <= LIMIT_RST;
         snap_ff   <= SNAP_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MATCH_RADIUS: radius_ff <= csr_wr_data;
            CSR_COUNT_LIMIT:  limit_ff  <= csr_wr_data[6:0];
            CSR_SNAP_HEIGHT:  snap_ff   <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      obs_pos_ff   <= obs_pos_in;
      obs_quat_ff  <= obs_quat_in;
      ent_ff       <= ent_in;
      new_ff       <= new_in;
      full_ff      <= full_in;
      zero_ff      <= zero_in;
      comp_ff      <= comp_in;
      prod_ff      <= prod_in;
      sign_ff      <= sign_in;
      sum_ff       <= sum_in;
      norm_ff      <= norm_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_quat_ff  <= rsp_quat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_id     = rsp_id_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_mean_x       = rsp_pos_ff[0];
   assign rsp_mean_y       = rsp_pos_ff[1];
   assign rsp_mean_z       = rsp_pos_ff[2];
   assign rsp_mean_qx      = rsp_quat_ff[0];
   assign rsp_mean_qy      = rsp_quat_ff[1];
   assign rsp_mean_qz      = rsp_quat_ff[2];
   assign rsp_mean_qw      = rsp_quat_ff[3];

endmodule

@@ hdl/lat_entry_ram.sv @@
// ----------------------------------------------------------------------------
// Landmark association table entry RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lat_entry_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lat_divider.sv @@
// ----------------------------------------------------------------------------
// Landmark association table divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lat_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lat_pkg::DIV_W-1:0] num,
   input  logic [lat_pkg::DEN_W-1:0] den,
   output logic                      done,
   output logic [lat_pkg::DIV_W-1:0] quo
);
   import lat_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ hdl/lat_isqrt.sv @@
// ----------------------------------------------------------------------------
// Landmark association table square root
// Bit-pair integer square root, floor result, one step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lat_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lat_pkg::SQ_W-1:0]   val,
   output logic                       done,
   output logic [lat_pkg::ROOT_W-1:0] root
);
   import lat_pkg::*;

   localparam int RW = SQ_W + 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW-1:0] v_ff, v_in;
   logic [RW-1:0] r_ff, r_in;
   logic [RW-1:0] bit_ff, bit_in;
   logic [RW:0]   trial;

   always_comb begin
      trial   = {1'b0, r_ff} + {1'b0, bit_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = {1'b0, val};
         r_in    = '0;
         bit_in  = RW'(1) << (SQ_W - 1);
      end else if (busy_ff) begin
         if ({1'b0, v_ff} >= trial) begin
            v_in = v_ff - trial[RW-1:0];
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

endmodule

@@ hdl/lat_checker.sv @@
// ----------------------------------------------------------------------------
// Landmark association table port checker
// Port-level properties of the unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "landmark_association_table_unit_macros.svh"

module lat_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_entry_id,
   input logic        rsp_is_new,
   input logic        rsp_table_full,
   input logic [7:0]  rsp_sample_count,
   input logic [31:0] rsp_mean_x
);

   `LAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_entry_id) && $stable(rsp_sample_count) && $stable(rsp_mean_x), "stalled result beat changed")
   `LAT_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "request beat taken while busy")
   `LAT_ASSERT_NOW(a_full_empty, rsp_valid && rsp_table_full, !rsp_is_new && rsp_entry_id == 16'd0 && rsp_sample_count == 8'd0, "full result carries entry data")
   `LAT_ASSERT_NOW(a_new_count, rsp_valid && rsp_is_new, rsp_sample_count == 8'd1 && !rsp_table_full, "new entry count not one")

endmodule

bind landmark_association_table_unit lat_checker u_lat_checker (.*);

@@ tb/landmark_association_table_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Landmark association table unit testbench
// Sends landmark observations and clear commands, keeps an independent model
// of the table, the running means and the quaternion renormalization, and
// compares every response beat field by field with the model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module landmark_association_table_unit_tb;
   import lat_pkg::*;

   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [15:0]        entry_id;
      logic               is_new;
      logic               table_full;
      logic [7:0]         sample_count;
      logic signed [31:0] mean_x;
      logic signed [31:0] mean_y;
      logic signed [31:0] mean_z;
      logic signed [15:0] mean_qx;
      logic signed [15:0] mean_qy;
      logic signed [15:0] mean_qz;
      logic signed [15:0] mean_qw;
   } landmark_rsp_type;

   logic               clock, reset;
   logic               req_valid, req_stall, req_cmd;
   logic [15:0]        req_tag_key;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [15:0] req_quat_x, req_quat_y, req_quat_z, req_quat_w;
   logic               rsp_valid, rsp_stall;
   logic [15:0]        rsp_entry_id;
   logic               rsp_is_new, rsp_table_full;
   logic [7:0]         rsp_sample_count;
   logic signed [31:0] rsp_mean_x, rsp_mean_y, rsp_mean_z;
   logic signed [15:0] rsp_mean_qx, rsp_mean_qy, rsp_mean_qz, rsp_mean_qw;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [30:0]        csr_wr_data;

   landmark_association_table_unit uut (.*);

   // model state
   logic [30:0] cfg_radius;
   logic [6:0]  cfg_limit;
   logic        cfg_snap;
   bit          tbl_valid [TABLE_DEPTH];
   logic [15:0] tbl_key [TABLE_DEPTH];
   logic [15:0] tbl_ident [TABLE_DEPTH];
   longint      tbl_count [TABLE_DEPTH];
   longint      tbl_pos [TABLE_DEPTH][3];
   longint      tbl_quat [TABLE_DEPTH][4];
   int          tbl_fill;
   logic [15:0] ident_next;

   landmark_rsp_type pending_results [$];
   int error_count, req_beats, quiet_cycles;
   int tx_idle_pct, rx_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint abs_diff(longint a, longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic landmark_rsp_type associate_landmark(
         logic cmd, logic [15:0] key, logic signed [31:0] px, logic signed [31:0] py,
         logic signed [31:0] pz, logic signed [15:0] qx, logic signed [15:0] qy,
         logic signed [15:0] qz, logic signed [15:0] qw);
      landmark_rsp_type r;
      longint p [3];
      longint q [4];
      longint c [4];
      longint n, v, zz;
      longint unsigned s, nrm;
      int hit, i, k;
      r = '0;
      if (cmd == CMD_CLEAR) begin
         foreach (tbl_valid[j]) tbl_valid[j] = 0;
         tbl_fill = 0;
         return r;
      end
      p[0] = px; p[1] = py; p[2] = pz;
      q[0] = qx; q[1] = qy; q[2] = qz; q[3] = qw;
      hit = -1;
      for (i = 0; i < tbl_fill; i++)
         if (hit < 0 && tbl_valid[i] && tbl_key[i] == key
             && abs_diff(tbl_pos[i][0], p[0]) <= longint'(cfg_radius)
             && abs_diff(tbl_pos[i][1], p[1]) <= longint'(cfg_radius)
             && abs_diff(tbl_pos[i][2], p[2]) <= longint'(cfg_radius))
            hit = i;
      if (hit >= 0) begin
         i = hit;
         if (tbl_count[i] <= longint'(cfg_limit)) begin
            n = tbl_count[i];
            s = 0;
            for (k = 0; k < 3; k++) tbl_pos[i][k] = round_div(tbl_pos[i][k] * n + p[k], n + 1);
            for (k = 0; k < 4; k++) begin
               c[k] = round_div(tbl_quat[i][k] * n + q[k], n + 1);
               s += longint'(c[k] * c[k]);
            end
            nrm = int_sqrt(s);
            if (nrm == 0) begin
               c[0] = 0; c[1] = 0; c[2] = 0; c[3] = 16384;
            end else begin
               for (k = 0; k < 4; k++) begin
                  v = round_div(c[k] * 16384, longint'(nrm));
                  if (v > 16384) v = 16384;
                  if (v < -16384) v = -16384;
                  c[k] = v;
               end
            end
            for (k = 0; k < 4; k++) tbl_quat[i][k] = c[k];
            tbl_count[i] = n + 1;
         end
      end else if (tbl_fill < TABLE_DEPTH) begin
         i = tbl_fill;
         tbl_valid[i] = 1;
         tbl_key[i] = key;
         tbl_count[i] = 1;
         tbl_ident[i] = ident_next;
         ident_next = ident_next + 16'd1;
         for (k = 0; k < 3; k++) tbl_pos[i][k] = p[k];
         for (k = 0; k < 4; k++) tbl_quat[i][k] = q[k];
         tbl_fill++;
         r.is_new = 1'b1;
      end else begin
         r.table_full = 1'b1;
         return r;
      end
      zz = tbl_pos[i][2];
      if (cfg_snap) zz = (zz < 98304) ? 65536 : 131072;
      r.entry_id     = tbl_ident[i];
      r.sample_count = tbl_count[i][7:0];
      r.mean_x       = tbl_pos[i][0][31:0];
      r.mean_y       = tbl_pos[i][1][31:0];
      r.mean_z       = zz[31:0];
      r.mean_qx      = tbl_quat[i][0][15:0];
      r.mean_qy      = tbl_quat[i][1][15:0];
      r.mean_qz      = tbl_quat[i][2][15:0];
      r.mean_qw      = tbl_quat[i][3][15:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      error_count++;
      $display("MISMATCH %0t %s: got %0d expected %0d", $realtime, field, got, want);
   endtask

   task automatic compare_field(string field, longint got, longint want);
      if (got != want) report_mismatch(field, got, want);
   endtask

   // response checking and request prediction
   always @(posedge clock) begin
      landmark_rsp_type w;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               w = pending_results.pop_front();
               compare_field("entry_id", rsp_entry_id, w.entry_id);
               compare_field("is_new", rsp_is_new, w.is_new);
               compare_field("table_full", rsp_table_full, w.table_full);
               compare_field("sample_count", rsp_sample_count, w.sample_count);
               compare_field("mean_x", rsp_mean_x, w.mean_x);
               compare_field("mean_y", rsp_mean_y, w.mean_y);
               compare_field("mean_z", rsp_mean_z, w.mean_z);
               compare_field("mean_qx", rsp_mean_qx, w.mean_qx);
               compare_field("mean_qy", rsp_mean_qy, w.mean_qy);
               compare_field("mean_qz", rsp_mean_qz, w.mean_qz);
               compare_field("mean_qw", rsp_mean_qw, w.mean_qw);
            end
         end
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            w = associate_landmark(req_cmd, req_tag_key, req_pos_x, req_pos_y, req_pos_z,
                                   req_quat_x, req_quat_y, req_quat_z, req_quat_w);
            pending_results.insert(pending_results.size(), w);
            req_beats++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("landmark_association_table_unit_tb: errors");
            $finish;
         end
      end
   end

   always @(negedge clock)
      rsp_stall = ($urandom_range(0, 99) < rx_idle_pct);

   task automatic send_item(logic cmd, logic [15:0] key, logic signed [31:0] px,
         logic signed [31:0] py, logic signed [31:0] pz, logic signed [15:0] qx,
         logic signed [15:0] qy, logic signed [15:0] qz, logic signed [15:0] qw);
      int start;
      if ($urandom_range(0, 99) < tx_idle_pct)
         repeat ($urandom_range(1, 6)) @(negedge clock);
      req_cmd = cmd; req_tag_key = key;
      req_pos_x = px; req_pos_y = py; req_pos_z = pz;
      req_quat_x = qx; req_quat_y = qy; req_quat_z = qz; req_quat_w = qw;
      req_valid = 1'b1;
      start = req_beats;
      while (req_beats == start) @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [30:0] data);
      csr_wr_en = 1'b1; csr_index = idx; csr_wr_data = data;
      case (idx)
         CSR_MATCH_RADIUS: cfg_radius = data;
         CSR_COUNT_LIMIT:  cfg_limit = data[6:0];
         default:          cfg_snap = data[0];
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic observe(logic [15:0] key, logic signed [31:0] px, logic signed [31:0] py,
         logic signed [31:0] pz, logic signed [15:0] qx, logic signed [15:0] qy,
         logic signed [15:0] qz, logic signed [15:0] qw);
      send_item(CMD_OBSERVE, key, px, py, pz, qx, qy, qz, qw);
   endtask

   task automatic clear_table();
      send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic test_defaults();
      observe(16'd5, 0, 0, 32'sd98304, 0, 0, 0, Q_ONE);
      observe(16'd5, 32'sd65536, -32'sd65536, 32'sd98304, 0, 0, Q_ONE, Q_ONE);
      observe(16'd5, 0, 0, 32'sd98303, 0, 0, 0, Q_ONE);
      observe(16'd6, 0, 0, 32'sd98303, -16'sd16384, 0, 0, 0);
      wait_drained();
   endtask

   task automatic test_extremes();
      csr_write(CSR_SNAP_HEIGHT, 31'd0);
      csr_write(CSR_MATCH_RADIUS, 31'h7FFFFFFF);
      observe(16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              Q_ONE, -Q_ONE, Q_ONE, -Q_ONE);
      observe(16'hFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
              Q_ONE, Q_ONE, -Q_ONE, -Q_ONE);
      observe(16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              -Q_ONE, Q_ONE, -Q_ONE, Q_ONE);
      observe(16'hFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
              16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      wait_drained();
   endtask

   task automatic test_zero_quaternion();
      csr_write(CSR_MATCH_RADIUS, 31'd0);
      observe(16'd7, 100, 100, 100, Q_ONE, 0, 0, 0);
      observe(16'd7, 100, 100, 100, -Q_ONE, 0, 0, 0);
      observe(16'd7, 101, 100, 100, 0, 0, 0, 0);
      wait_drained();
   endtask

   task automatic test_count_limit();
      csr_write(CSR_COUNT_LIMIT, 31'd0);
      observe(16'd9, 500, 500, 500, 0, Q_ONE, 0, 0);
      observe(16'd9, 500, 500, 500, 0, 0, Q_ONE, 0);
      wait_drained();
      csr_write(CSR_COUNT_LIMIT, 31'd127);
      observe(16'd9, 500, 500, 500, 0, 0, Q_ONE, 0);
      wait_drained();
   endtask

   task automatic test_clear();
      clear_table();
      observe(16'd5, 0, 0, 0, 0, 0, 0, Q_ONE);
      clear_table();
      wait_drained();
   endtask

   task automatic random_observation();
      logic [15:0] key;
      logic signed [31:0] pos [3];
      logic signed [15:0] qc [4];
      int spread;
      if ($urandom_range(0, 119) == 0) begin
         clear_table();
      end else if ($urandom_range(0, 9) < 2) begin
         observe($urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
      end else begin
         key = $urandom_range(0, 40);
         spread = ($urandom_range(0, 9) < 7) ? 40000 : 300000;
         for (int k = 0; k < 3; k++)
            pos[k] = key * 32'sd196608 + $urandom_range(0, 2 * spread) - spread;
         if ($urandom_range(0, 1)) pos[2] = 32'sd98304 + $urandom_range(0, 2000) - 1000;
         for (int k = 0; k < 4; k++) qc[k] = $urandom_range(0, 32768) - 16384;
         observe(key, pos[0], pos[1], pos[2], qc[0], qc[1], qc[2], qc[3]);
      end
   endtask

   task automatic test_random(int items, int tx_pct, int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < items; i++) begin
         random_observation();
         if (i % 200 == 199) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      error_count = 0; req_beats = 0; quiet_cycles = 0;
      tx_idle_pct = 14; rx_idle_pct = 79;
      reset = 1'b1;
      req_valid = 1'b0; req_cmd = CMD_OBSERVE; req_tag_key = '0;
      req_pos_x = '0; req_pos_y = '0; req_pos_z = '0;
      req_quat_x = '0; req_quat_y = '0; req_quat_z = '0; req_quat_w = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0; csr_index = CSR_MATCH_RADIUS; csr_wr_data = '0;
      cfg_radius = RADIUS_RST; cfg_limit = LIMIT_RST; cfg_snap = SNAP_RST;
      foreach (tbl_valid[j]) tbl_valid[j] = 0;
      tbl_fill = 0; ident_next = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_defaults();
      test_extremes();
      test_zero_quaternion();
      test_count_limit();
      test_clear();

      csr_write(CSR_MATCH_RADIUS, 31'd65536);
      csr_write(CSR_COUNT_LIMIT, 31'd3);
      csr_write(CSR_SNAP_HEIGHT, 31'd1);
      test_random(550, 14, 79);
      csr_write(CSR_MATCH_RADIUS, 31'h7FFFFFFF);
      csr_write(CSR_COUNT_LIMIT, 31'd127);
      csr_write(CSR_SNAP_HEIGHT, 31'd0);
      test_random(550, 79, 14);
      csr_write(CSR_MATCH_RADIUS, $urandom_range(1000, 120000));
      csr_write(CSR_COUNT_LIMIT, $urandom_range(0, 127));
      csr_write(CSR_SNAP_HEIGHT, $urandom_range(0, 1));
      test_random(550, 0, 0);

      repeat (600) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("landmark_association_table_unit_tb: clean");
      else
         $display("landmark_association_table_unit_tb: errors");
      $finish;
   end

endmodule
